### design/rbl_pkg.sv
// Package for the ring bin load rebalancer: sizes, codes and sequencer states.
// No dependencies; rbl_if.sv and the top level refer to it by scoped names.
package rbl_pkg;

   localparam int NUM_BINS  = 1024;
   localparam int IDX_BITS  = $clog2(NUM_BINS);
   localparam int CNT_BITS  = IDX_BITS + 1;
   localparam int LOAD_BITS = 24;
   localparam int OUT_BITS  = 24;
   localparam int Q_BITS    = 16;
   localparam int PROD_BITS = Q_BITS + LOAD_BITS;
   localparam int CSR_IDX_BITS = 1;

   localparam logic [LOAD_BITS-1:0] LOAD_MAX = {LOAD_BITS{1'b1}};
   localparam logic [Q_BITS-1:0] ALPHA_RESET = Q_BITS'(1399);
   localparam logic [Q_BITS-1:0] BETA_RESET  = Q_BITS'(1050);

   localparam logic [CSR_IDX_BITS-1:0] CSR_ALPHA = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BETA  = 1'b1;

   localparam logic [1:0] ACT_NONE  = 2'd0;
   localparam logic [1:0] ACT_MERGE = 2'd1;
   localparam logic [1:0] ACT_EVEN  = 2'd2;

   typedef enum logic [1:0] {
      SCAN_MIN,
      SCAN_MAX,
      SCAN_FIN
   } scan_kind_type;

   typedef enum logic [4:0] {
      ST_CLR,
      ST_IDLE,
      ST_RDU,
      ST_LDU,
      ST_SCAN,
      ST_MUL,
      ST_TEST,
      ST_NBA,
      ST_NBB,
      ST_NBC,
      ST_MULZ,
      ST_TESTZ,
      ST_EV1,
      ST_EV2,
      ST_MRG,
      ST_SHD,
      ST_XR,
      ST_XC,
      ST_SHU,
      ST_SP1,
      ST_SP2,
      ST_DONE
   } state_type;

endpackage

### design/rbl_if.sv
// Request and response channel interfaces of the ring bin load rebalancer.
// Depends on rbl_pkg for field widths.
interface rbl_req_if;
   logic                         valid;
   logic                         ready;
   logic                         mode;
   logic [rbl_pkg::IDX_BITS-1:0] bin_index;

   modport source (output valid, mode, bin_index, input ready);
   modport sink   (input valid, mode, bin_index, output ready);
endinterface

interface rbl_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [1:0]                   action;
   logic [rbl_pkg::IDX_BITS-1:0] removed_index;
   logic [rbl_pkg::IDX_BITS-1:0] neighbour_index;
   logic [rbl_pkg::IDX_BITS-1:0] split_index;
   logic [rbl_pkg::OUT_BITS-1:0] min_load;
   logic [rbl_pkg::OUT_BITS-1:0] max_load;
   logic                         saturated;

   modport source (output valid, action, removed_index, neighbour_index, split_index,
                   min_load, max_load, saturated, input ready);
   modport sink   (input valid, action, removed_index, neighbour_index, split_index,
                   min_load, max_load, saturated, output ready);
endinterface

### design/rbl_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module rbl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### design/ring_bin_load_rebalancer_top.sv
// Top level of the ring bin load rebalancer: sequencer around one bin load RAM.
// Depends on rbl_pkg, rbl_if.sv (channel interfaces) and rbl_ram.
//
//  channel   direction  handshake         payload
//  req_ch    in         valid / ready     mode, bin_index
//  rsp_ch    out        valid / ready     action, indices, min/max load, saturated
//  csr_*     in         csr_we only       csr_index, csr_wdata (alpha, beta)
//
// Work: one request at a time. A request that changes nothing makes 2 full RAM
//   sweeps (search, final min/max); a merge and split makes up to 4 sweeps
//   (search, shift down, shift up, final min/max), each paced by the single
//   RAM read port, one entry per cycle.
// Reset: a clearing pass writes every bin to zero, with req ready low.
// Stalls: the response sits in an output register; a new request is taken while
//   it waits, and the next result holds in DONE until the slot frees.
module ring_bin_load_rebalancer_top (
   input  logic                             clock,
   input  logic                             reset,
   rbl_req_if.sink                          req_ch,
   rbl_rsp_if.source                        rsp_ch,
   input  logic                             csr_we,
   input  logic [rbl_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [rbl_pkg::Q_BITS-1:0]       csr_wdata
);

   localparam int IW = rbl_pkg::IDX_BITS;
   localparam int CW = rbl_pkg::CNT_BITS;
   localparam int LW = rbl_pkg::LOAD_BITS;
   localparam int PW = rbl_pkg::PROD_BITS;
   localparam logic [IW-1:0] LAST = IW'(rbl_pkg::NUM_BINS - 1);
   localparam logic [CW-1:0] CNT_END = CW'(rbl_pkg::NUM_BINS);

   rbl_pkg::state_type     state_ff, state_in;
   rbl_pkg::scan_kind_type kind_ff, kind_in;

   logic [rbl_pkg::Q_BITS-1:0] alpha_ff, beta_ff;

   logic          mode_ff, mode_in;
   logic [IW-1:0] u_ff, u_in;
   logic [LW-1:0] lu_ff, lu_in;
   logic [IW-1:0] src_ff, src_in;
   logic [LW-1:0] lsrc_ff, lsrc_in;
   logic [IW-1:0] heavy_ff, heavy_in;
   logic [IW-1:0] h_ff, h_in;
   logic [IW-1:0] z_ff, z_in;
   logic [LW-1:0] lz_ff, lz_in;
   logic [LW-1:0] ll_ff, ll_in;
   logic [LW-1:0] x_ff, x_in;
   logic [PW-1:0] prod_ff, prod_in;
   logic [CW-1:0] rc_ff, rc_in;
   logic [IW-1:0] wa_ff, wa_in;
   logic          pend_ff, pend_in;
   logic [IW-1:0] min_idx_ff, min_idx_in, max_idx_ff, max_idx_in;
   logic [LW-1:0] min_ff, min_in, max_ff, max_in;

   logic [1:0]    act_ff, act_in;
   logic [IW-1:0] rem_ff, rem_in, nb_ff, nb_in, sidx_ff, sidx_in;
   logic          sat_ff, sat_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_act_ff, rsp_act_in;
   logic [IW-1:0] rsp_rem_ff, rsp_rem_in, rsp_nb_ff, rsp_nb_in, rsp_sidx_ff, rsp_sidx_in;
   logic [rbl_pkg::OUT_BITS-1:0] rsp_min_ff, rsp_min_in, rsp_max_ff, rsp_max_in;
   logic          rsp_sat_ff, rsp_sat_in;

   // RAM ports
   logic          ram_we;
   logic [IW-1:0] ram_waddr, ram_raddr;
   logic [LW-1:0] ram_wdata, ram_rdata;

   // arithmetic helpers
   logic [rbl_pkg::Q_BITS-1:0] mul_a;
   logic [LW-1:0] mul_b;
   logic [IW-1:0] left_idx, right_idx;
   logic [LW:0]   pair_sum, merge_sum, x_plus;
   logic          issue;

   rbl_ram #(
      .WIDTH (LW),
      .DEPTH (rbl_pkg::NUM_BINS)
   ) u_loads (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // Configuration registers, taken at any time
   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= rbl_pkg::ALPHA_RESET;
         beta_ff  <= rbl_pkg::BETA_RESET;
      end else if (csr_we) begin
         case (csr_index)
            rbl_pkg::CSR_ALPHA: alpha_ff <= csr_wdata;
            rbl_pkg::CSR_BETA:  beta_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign left_idx  = (src_ff == '0) ? LAST : src_ff - 1'b1;
   assign right_idx = (src_ff == LAST) ? '0 : src_ff + 1'b1;
   assign pair_sum  = {1'b0, lu_ff} + {1'b0, lz_ff};
   assign merge_sum = {1'b0, lz_ff} + {1'b0, lsrc_ff};
   assign x_plus    = {1'b0, x_ff} + 1'b1;
   assign prod_in   = mul_a * mul_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rbl_pkg::ST_CLR;
         rc_ff        <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rc_ff        <= rc_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      mode_ff    <= mode_in;
      u_ff       <= u_in;
      lu_ff      <= lu_in;
      src_ff     <= src_in;
      lsrc_ff    <= lsrc_in;
      heavy_ff   <= heavy_in;
      h_ff       <= h_in;
      z_ff       <= z_in;
      lz_ff      <= lz_in;
      ll_ff      <= ll_in;
      x_ff       <= x_in;
      prod_ff    <= prod_in;
      wa_ff      <= wa_in;
      min_idx_ff <= min_idx_in;
      max_idx_ff <= max_idx_in;
      min_ff     <= min_in;
      max_ff     <= max_in;
      act_ff     <= act_in;
      rem_ff     <= rem_in;
      nb_ff      <= nb_in;
      sidx_ff    <= sidx_in;
      sat_ff     <= sat_in;
      rsp_act_ff  <= rsp_act_in;
      rsp_rem_ff  <= rsp_rem_in;
      rsp_nb_ff   <= rsp_nb_in;
      rsp_sidx_ff <= rsp_sidx_in;
      rsp_min_ff  <= rsp_min_in;
      rsp_max_ff  <= rsp_max_in;
      rsp_sat_ff  <= rsp_sat_in;
   end

   always_comb begin
      state_in = state_ff;
      kind_in = kind_ff;
      mode_in = mode_ff;
      u_in = u_ff;
      lu_in = lu_ff;
      src_in = src_ff;
      lsrc_in = lsrc_ff;
      heavy_in = heavy_ff;
      h_in = h_ff;
      z_in = z_ff;
      lz_in = lz_ff;
      ll_in = ll_ff;
      x_in = x_ff;
      rc_in = rc_ff;
      wa_in = wa_ff;
      pend_in = 1'b0;
      min_idx_in = min_idx_ff;
      max_idx_in = max_idx_ff;
      min_in = min_ff;
      max_in = max_ff;
      act_in = act_ff;
      rem_in = rem_ff;
      nb_in = nb_ff;
      sidx_in = sidx_ff;
      sat_in = sat_ff;
      rsp_act_in = rsp_act_ff;
      rsp_rem_in = rsp_rem_ff;
      rsp_nb_in = rsp_nb_ff;
      rsp_sidx_in = rsp_sidx_ff;
      rsp_min_in = rsp_min_ff;
      rsp_max_in = rsp_max_ff;
      rsp_sat_in = rsp_sat_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ch.ready;
      ram_we = 1'b0;
      ram_waddr = wa_ff;
      ram_wdata = ram_rdata;
      ram_raddr = rc_ff[IW-1:0];
      mul_a = beta_ff;
      mul_b = lz_ff;
      issue = 1'b0;
      req_ch.ready = 1'b0;

      case (state_ff)
         rbl_pkg::ST_CLR: begin
            // zero one bin per cycle
            ram_we = 1'b1;
            ram_waddr = rc_ff[IW-1:0];
            ram_wdata = '0;
            rc_in = rc_ff + 1'b1;
            if (rc_ff[IW-1:0] == LAST) begin
               state_in = rbl_pkg::ST_IDLE;
            end
         end
         rbl_pkg::ST_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               mode_in = req_ch.mode;
               u_in = req_ch.bin_index;
               act_in = rbl_pkg::ACT_NONE;
               rem_in = '0;
               nb_in = '0;
               sidx_in = '0;
               sat_in = 1'b0;
               state_in = rbl_pkg::ST_RDU;
            end
         end
         rbl_pkg::ST_RDU: begin
            ram_raddr = u_ff;
            state_in = rbl_pkg::ST_LDU;
         end
         rbl_pkg::ST_LDU: begin
            // mode 0 bumps the addressed bin; mode 1 only keeps its load
            lu_in = ram_rdata;
            if (!mode_ff) begin
               if (ram_rdata == rbl_pkg::LOAD_MAX) begin
                  sat_in = 1'b1;
               end else begin
                  lu_in = ram_rdata + 1'b1;
               end
               ram_we = 1'b1;
               ram_waddr = u_ff;
               ram_wdata = lu_in;
               kind_in = rbl_pkg::SCAN_MIN;
            end else begin
               kind_in = rbl_pkg::SCAN_MAX;
            end
            rc_in = '0;
            state_in = rbl_pkg::ST_SCAN;
         end
         rbl_pkg::ST_SCAN: begin
            // sweep all bins, first index wins ties for both min and max
            issue = (rc_ff != CNT_END);
            if (issue) begin
               wa_in = rc_ff[IW-1:0];
               rc_in = rc_ff + 1'b1;
               pend_in = 1'b1;
            end
            if (pend_ff) begin
               if (wa_ff == '0) begin
                  min_in = ram_rdata;
                  max_in = ram_rdata;
                  min_idx_in = '0;
                  max_idx_in = '0;
               end else begin
                  if (ram_rdata < min_ff) begin
                     min_in = ram_rdata;
                     min_idx_in = wa_ff;
                  end
                  if (ram_rdata > max_ff) begin
                     max_in = ram_rdata;
                     max_idx_in = wa_ff;
                  end
               end
            end
            if (!issue && !pend_ff) begin
               state_in = (kind_ff == rbl_pkg::SCAN_FIN) ? rbl_pkg::ST_DONE
                                                         : rbl_pkg::ST_MUL;
            end
         end
         rbl_pkg::ST_MUL: begin
            mul_a = mode_ff ? beta_ff : alpha_ff;
            mul_b = mode_ff ? lu_ff : min_ff;
            state_in = rbl_pkg::ST_TEST;
         end
         rbl_pkg::ST_TEST: begin
            kind_in = rbl_pkg::SCAN_FIN;
            rc_in = '0;
            state_in = rbl_pkg::ST_SCAN;
            if (!mode_ff) begin
               if (min_idx_ff != u_ff && PW'({lu_ff, 8'h00}) > prod_ff) begin
                  src_in = min_idx_ff;
                  lsrc_in = min_ff;
                  heavy_in = u_ff;
                  act_in = rbl_pkg::ACT_MERGE;
                  rem_in = min_idx_ff;
                  state_in = rbl_pkg::ST_NBA;
               end
            end else begin
               if (max_idx_ff != u_ff && prod_ff < PW'({max_ff, 8'h00})) begin
                  src_in = u_ff;
                  lsrc_in = lu_ff;
                  heavy_in = max_idx_ff;
                  state_in = rbl_pkg::ST_NBA;
               end
            end
         end
         rbl_pkg::ST_NBA: begin
            ram_raddr = left_idx;
            state_in = rbl_pkg::ST_NBB;
         end
         rbl_pkg::ST_NBB: begin
            ram_raddr = right_idx;
            ll_in = ram_rdata;
            state_in = rbl_pkg::ST_NBC;
         end
         rbl_pkg::ST_NBC: begin
            // lighter neighbour, right wins ties
            if (ll_ff < ram_rdata) begin
               z_in = left_idx;
               lz_in = ll_ff;
            end else begin
               z_in = right_idx;
               lz_in = ram_rdata;
            end
            state_in = mode_ff ? rbl_pkg::ST_MULZ : rbl_pkg::ST_MRG;
         end
         rbl_pkg::ST_MULZ: begin
            state_in = rbl_pkg::ST_TESTZ;
         end
         rbl_pkg::ST_TESTZ: begin
            rem_in = u_ff;
            if (prod_ff <= PW'({max_ff, 9'h000})) begin
               act_in = rbl_pkg::ACT_MERGE;
               state_in = rbl_pkg::ST_MRG;
            end else begin
               act_in = rbl_pkg::ACT_EVEN;
               nb_in = z_ff;
               state_in = rbl_pkg::ST_EV1;
            end
         end
         rbl_pkg::ST_EV1: begin
            ram_we = 1'b1;
            ram_waddr = u_ff;
            ram_wdata = LW'((pair_sum + 1'b1) >> 1);
            state_in = rbl_pkg::ST_EV2;
         end
         rbl_pkg::ST_EV2: begin
            ram_we = 1'b1;
            ram_waddr = z_ff;
            ram_wdata = LW'(pair_sum >> 1);
            kind_in = rbl_pkg::SCAN_FIN;
            rc_in = '0;
            state_in = rbl_pkg::ST_SCAN;
         end
         rbl_pkg::ST_MRG: begin
            // fold the source into its neighbour, clamp at the load limit
            ram_we = 1'b1;
            ram_waddr = z_ff;
            if (merge_sum[LW]) begin
               ram_wdata = rbl_pkg::LOAD_MAX;
               sat_in = 1'b1;
            end else begin
               ram_wdata = merge_sum[LW-1:0];
            end
            nb_in = z_ff;
            h_in = (src_ff < heavy_ff) ? heavy_ff - 1'b1 : heavy_ff;
            rc_in = CW'(src_ff) + 1'b1;
            state_in = rbl_pkg::ST_SHD;
         end
         rbl_pkg::ST_SHD: begin
            // close the gap: read entry i, write it to i-1 in the following cycle
            issue = (rc_ff != CNT_END);
            if (issue) begin
               wa_in = IW'(rc_ff - 1'b1);
               rc_in = rc_ff + 1'b1;
               pend_in = 1'b1;
            end
            ram_we = pend_ff;
            if (!issue && !pend_ff) begin
               state_in = rbl_pkg::ST_XR;
            end
         end
         rbl_pkg::ST_XR: begin
            ram_raddr = h_ff;
            state_in = rbl_pkg::ST_XC;
         end
         rbl_pkg::ST_XC: begin
            x_in = ram_rdata;
            rc_in = CW'(LAST);
            state_in = rbl_pkg::ST_SHU;
         end
         rbl_pkg::ST_SHU: begin
            // open a slot after the heavy bin, top entry first
            issue = (rc_ff != CW'(h_ff));
            if (issue) begin
               ram_raddr = IW'(rc_ff - 1'b1);
               wa_in = rc_ff[IW-1:0];
               rc_in = rc_ff - 1'b1;
               pend_in = 1'b1;
            end
            ram_we = pend_ff;
            if (!issue && !pend_ff) begin
               state_in = rbl_pkg::ST_SP1;
            end
         end
         rbl_pkg::ST_SP1: begin
            ram_we = 1'b1;
            ram_waddr = h_ff;
            ram_wdata = x_ff >> 1;
            state_in = rbl_pkg::ST_SP2;
         end
         rbl_pkg::ST_SP2: begin
            ram_we = 1'b1;
            ram_waddr = h_ff + 1'b1;
            ram_wdata = LW'(x_plus >> 1);
            sidx_in = h_ff;
            kind_in = rbl_pkg::SCAN_FIN;
            rc_in = '0;
            state_in = rbl_pkg::ST_SCAN;
         end
         rbl_pkg::ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_act_in = act_ff;
               rsp_rem_in = rem_ff;
               rsp_nb_in = nb_ff;
               rsp_sidx_in = sidx_ff;
               rsp_min_in = rbl_pkg::OUT_BITS'(min_ff);
               rsp_max_in = rbl_pkg::OUT_BITS'(max_ff);
               rsp_sat_in = sat_ff;
               state_in = rbl_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rbl_pkg::ST_IDLE;
         end
      endcase
   end

   // in the MULZ state the default multiplier operands (beta, neighbour load) apply

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.action          = rsp_act_ff;
   assign rsp_ch.removed_index   = rsp_rem_ff;
   assign rsp_ch.neighbour_index = rsp_nb_ff;
   assign rsp_ch.split_index     = rsp_sidx_ff;
   assign rsp_ch.min_load        = rsp_min_ff;
   assign rsp_ch.max_load        = rsp_max_ff;
   assign rsp_ch.saturated       = rsp_sat_ff;

   a_none_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_act_ff == rbl_pkg::ACT_NONE |->
         rsp_rem_ff == '0 && rsp_nb_ff == '0 && rsp_sidx_ff == '0)
      else $error("idle action carries nonzero indices");

   a_even_nosplit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_act_ff == rbl_pkg::ACT_EVEN |-> rsp_sidx_ff == '0)
      else $error("even-out reports a split index");

   a_min_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_min_ff <= rsp_max_ff)
      else $error("min load above max load");

   a_shift_no_clash: assert property (@(posedge clock) disable iff (reset)
      ram_we && (state_ff == rbl_pkg::ST_SHD || state_ff == rbl_pkg::ST_SHU) |->
         ram_waddr != ram_raddr || !issue)
      else $error("shift writes the entry it reads");

endmodule

### dv/testbench.sv
// Self-checking testbench for ring_bin_load_rebalancer_top: bursty request driver,
// stalling response monitor and an in-bench ring load predictor.
// Depends on rbl_pkg and the channel interfaces in design/rbl_if.sv.
module testbench;

   localparam int  NBINS       = rbl_pkg::NUM_BINS;
   localparam int  IW          = rbl_pkg::IDX_BITS;
   localparam int  OW          = rbl_pkg::OUT_BITS;
   localparam int  QW          = rbl_pkg::Q_BITS;
   localparam longint LMAX     = (64'd1 << rbl_pkg::LOAD_BITS) - 1;
   localparam int  LATENCY     = 5 * NBINS;
   localparam longint CYCLE_LIMIT = 60_000_000;

   typedef struct {
      logic          mode;
      logic [IW-1:0] bin;
   } request_type;

   typedef struct {
      logic [1:0]    action;
      logic [IW-1:0] removed;
      logic [IW-1:0] neighbour;
      logic [IW-1:0] split;
      logic [OW-1:0] min_load;
      logic [OW-1:0] max_load;
      logic          saturated;
   } outcome_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                                csr_we    = 1'b0;
   logic [rbl_pkg::CSR_IDX_BITS-1:0]    csr_index = rbl_pkg::CSR_ALPHA;
   logic [QW-1:0]                       csr_wdata = '0;

   rbl_req_if req_if ();
   rbl_rsp_if rsp_if ();

   ring_bin_load_rebalancer_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor state: bin loads and the two thresholds.
   longint unsigned ring_load [NBINS];
   longint unsigned alpha_q = longint'(rbl_pkg::ALPHA_RESET);
   longint unsigned beta_q  = longint'(rbl_pkg::BETA_RESET);

   request_type pending_reqs[$];
   outcome_type expected_outcomes[$];
   int errors = 0;
   int n_merge = 0, n_even = 0, n_none = 0;
   logic long_hold_go = 1'b0;

   function automatic int lightest_bin();
      int k = 0;
      for (int i = 1; i < NBINS; i++) if (ring_load[i] < ring_load[k]) k = i;
      return k;
   endfunction

   function automatic int heaviest_bin();
      int k = 0;
      for (int i = 1; i < NBINS; i++) if (ring_load[i] > ring_load[k]) k = i;
      return k;
   endfunction

   function automatic int lighter_side(int i);
      int l = (i == 0) ? NBINS - 1 : i - 1;
      int r = (i == NBINS - 1) ? 0 : i + 1;
      return (ring_load[l] < ring_load[r]) ? l : r;
   endfunction

   // Merge src into its lighter neighbour, drop src, then split heavy in two.
   function automatic int merge_and_split(int src, int heavy, output int nb,
                                          inout logic sat);
      int z = lighter_side(src);
      longint unsigned sum = ring_load[z] + ring_load[src];
      longint unsigned x;
      int h;
      if (sum > LMAX) begin
         sum = LMAX;
         sat = 1'b1;
      end
      ring_load[z] = sum;
      for (int i = src; i < NBINS - 1; i++) ring_load[i] = ring_load[i+1];
      h = (src < heavy) ? heavy - 1 : heavy;
      x = ring_load[h];
      for (int i = NBINS - 1; i > h; i--) ring_load[i] = ring_load[i-1];
      ring_load[h] = x / 2;
      if (h + 1 < NBINS) ring_load[h+1] = (x + 1) / 2;
      nb = z;
      return h;
   endfunction

   function automatic outcome_type rebalance(request_type rq);
      outcome_type o;
      int u = int'(rq.bin);
      int v, w, z, nb = 0, sidx = 0;
      longint unsigned sum;
      logic sat = 1'b0;
      o.action = rbl_pkg::ACT_NONE;
      o.removed = '0;
      if (u < NBINS) begin
         if (rq.mode == 1'b0) begin
            if (ring_load[u] >= LMAX) begin
               ring_load[u] = LMAX;
               sat = 1'b1;
            end else begin
               ring_load[u] = ring_load[u] + 1;
            end
            v = lightest_bin();
            if (v != u && ring_load[u] * 256 > alpha_q * ring_load[v]) begin
               o.action = rbl_pkg::ACT_MERGE;
               o.removed = IW'(v);
               sidx = merge_and_split(v, u, nb, sat);
            end
         end else begin
            w = heaviest_bin();
            if (w != u && beta_q * ring_load[u] < ring_load[w] * 256) begin
               z = lighter_side(u);
               if (beta_q * ring_load[z] <= ring_load[w] * 512) begin
                  o.action = rbl_pkg::ACT_MERGE;
                  o.removed = IW'(u);
                  sidx = merge_and_split(u, w, nb, sat);
               end else begin
                  sum = ring_load[u] + ring_load[z];
                  ring_load[u] = (sum + 1) / 2;
                  ring_load[z] = sum / 2;
                  o.action = rbl_pkg::ACT_EVEN;
                  o.removed = IW'(u);
                  nb = z;
               end
            end
         end
      end
      o.neighbour = IW'(nb);
      o.split     = IW'(sidx);
      o.min_load  = ring_load[lightest_bin()][OW-1:0];
      o.max_load  = ring_load[heaviest_bin()][OW-1:0];
      o.saturated = sat;
      return o;
   endfunction

   // Driver: bursts of requests separated by random gaps.
   int burst_left = 1;
   int gap_left   = 0;
   always @(posedge clock) begin
      request_type rq;
      if (reset) begin
         req_if.valid     <= 1'b0;
         req_if.mode      <= 1'b0;
         req_if.bin_index <= '0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            rq.mode = req_if.mode;
            rq.bin  = req_if.bin_index;
            expected_outcomes = {expected_outcomes, rebalance(rq)};
         end
         if (!req_if.valid || req_if.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_if.valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               rq = pending_reqs.pop_front();
               req_if.valid     <= 1'b1;
               req_if.mode      <= rq.mode;
               req_if.bin_index <= rq.bin;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 8);
                  // mostly short gaps, sometimes one longer than an item's work
                  gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3000)
                                                         : $urandom_range(0, 40);
               end
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: response ready follows its own stall pattern; one long hold-off.
   int stall_left = 0;
   int run_left   = 0;
   int long_hold  = 0;
   logic long_done = 1'b0;
   always @(posedge clock) begin
      outcome_type e;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_outcomes.size() == 0) begin
               $error("response with nothing expected");
               errors++;
            end else begin
               e = expected_outcomes.pop_front();
               if (rsp_if.action === rbl_pkg::ACT_MERGE) n_merge++;
               else if (rsp_if.action === rbl_pkg::ACT_EVEN) n_even++;
               else n_none++;
               if (rsp_if.action !== e.action) begin
                  $error("action exp %0d got %0d", e.action, rsp_if.action); errors++;
               end
               if (rsp_if.removed_index !== e.removed) begin
                  $error("removed_index exp %0d got %0d", e.removed, rsp_if.removed_index);
                  errors++;
               end
               if (rsp_if.neighbour_index !== e.neighbour) begin
                  $error("neighbour_index exp %0d got %0d", e.neighbour,
                         rsp_if.neighbour_index);
                  errors++;
               end
               if (rsp_if.split_index !== e.split) begin
                  $error("split_index exp %0d got %0d", e.split, rsp_if.split_index);
                  errors++;
               end
               if (rsp_if.min_load !== e.min_load) begin
                  $error("min_load exp %0d got %0d", e.min_load, rsp_if.min_load); errors++;
               end
               if (rsp_if.max_load !== e.max_load) begin
                  $error("max_load exp %0d got %0d", e.max_load, rsp_if.max_load); errors++;
               end
               if (rsp_if.saturated !== e.saturated) begin
                  $error("saturated exp %0d got %0d", e.saturated, rsp_if.saturated);
                  errors++;
               end
            end
         end
         if (long_hold_go && !long_done) begin
            // hold off long enough that the block fills up and stalls requests
            long_hold++;
            rsp_if.ready <= 1'b0;
            if (long_hold >= 20000) long_done <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else if (run_left > 0) begin
            run_left--;
            rsp_if.ready <= 1'b1;
         end else begin
            run_left = $urandom_range(0, 6000);
            stall_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 5000)
                                                     : $urandom_range(0, 3);
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // Timeout guard.
   longint cycles = 0;
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic push_req(logic m, int b);
      request_type rq;
      rq.mode = m;
      rq.bin  = IW'(b);
      pending_reqs = {pending_reqs, rq};
   endtask

   // Wait until the block is idle, then write both thresholds.
   task automatic set_thresholds(int a, int b);
      do @(negedge clock);
      while (pending_reqs.size() != 0 || req_if.valid || expected_outcomes.size() != 0);
      repeat (LATENCY) @(posedge clock);
      csr_we <= 1'b1; csr_index <= rbl_pkg::CSR_ALPHA; csr_wdata <= a[QW-1:0];
      alpha_q = longint'(a);
      @(posedge clock);
      csr_index <= rbl_pkg::CSR_BETA; csr_wdata <= b[QW-1:0];
      beta_q = longint'(b);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Random phase: mostly adds to a few hot bins so loads build up, some checks.
   task automatic random_phase(int count);
      int hot [4];
      for (int i = 0; i < 4; i++) hot[i] = $urandom_range(0, NBINS - 1);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 4) == 0)
            push_req(1'b1, $urandom_range(0, 9) < 3 ? hot[$urandom_range(0, 3)]
                                                    : $urandom_range(0, NBINS - 1));
         else if ($urandom_range(0, 3) != 0)
            push_req(1'b0, hot[$urandom_range(0, 3)]);
         else
            push_req(1'b0, $urandom_range(0, NBINS - 1));
      end
   endtask

   initial begin
      for (int i = 0; i < NBINS; i++) ring_load[i] = 0;
      req_if.valid = 1'b0;
      req_if.mode = 1'b0;
      req_if.bin_index = '0;
      rsp_if.ready = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: ring ends, wrap-around neighbours, checks on empty and loaded bins.
      push_req(1'b1, 0);
      push_req(1'b0, 0);
      push_req(1'b0, NBINS - 1);
      push_req(1'b0, NBINS - 1);
      push_req(1'b1, NBINS - 1);
      push_req(1'b0, 1);
      push_req(1'b0, 1);
      push_req(1'b0, 1);
      push_req(1'b1, 0);
      push_req(1'b1, 2);
      push_req(1'b0, 512);
      push_req(1'b0, 341);
      push_req(1'b0, 682);
      push_req(1'b1, 511);
      push_req(1'b1, 1);
      push_req(1'b0, NBINS - 2);
      push_req(1'b1, NBINS - 1);
      push_req(1'b1, 512);
      random_phase(30);

      // Pause until drained, then minimum alpha and beta with the long hold-off.
      set_thresholds(256, 257);
      long_hold_go <= 1'b1;
      random_phase(50);
      set_thresholds(65535, 65535);
      random_phase(45);
      set_thresholds(256, 65535);
      random_phase(45);
      set_thresholds(65535, 257);
      random_phase(45);
      set_thresholds($urandom_range(256, 2000), $urandom_range(257, 2000));
      random_phase(45);

      do @(negedge clock);
      while (pending_reqs.size() != 0 || req_if.valid || expected_outcomes.size() != 0);
      repeat (LATENCY) @(posedge clock);
      if (expected_outcomes.size() != 0) begin
         $error("%0d responses missing", expected_outcomes.size());
         errors++;
      end
      $display("Covered six threshold settings including both extremes;");
      $display("responses: %0d merge/split, %0d even-out, %0d no action, %0d errors",
               n_merge, n_even, n_none, errors);
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule

### sim.f
design/rbl_pkg.sv
design/rbl_if.sv
design/rbl_ram.sv
design/ring_bin_load_rebalancer_top.sv
dv/testbench.sv
